### src/per_source_packet_deframer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-source packet deframer
// Implication checks, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define PER_SOURCE_PACKET_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define PSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication
`define PSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### src/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int NumSourcesDef  = 16;
  localparam int BufferDepthDef = 128;
  localparam int MaxResults     = 64;
  localparam int NresW          = $clog2(MaxResults + 1);

  localparam logic [7:0] HeaderFirstRst  = 8'h31;
  localparam logic [7:0] HeaderSecondRst = 8'h6B;
  localparam logic [6:0] LengthLimitRst  = 7'h21;

  localparam logic [1:0] CfgHeaderFirst  = 2'd0;
  localparam logic [1:0] CfgHeaderSecond = 2'd1;
  localparam logic [1:0] CfgLengthLimit  = 2'd2;

  localparam logic [2:0] StData     = 3'd0;
  localparam logic [2:0] StChecksum = 3'd1;
  localparam logic [2:0] StLength   = 3'd2;
  localparam logic [2:0] StEmpty    = 3'd3;
  localparam logic [2:0] StOverflow = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_APPEND, S_HUNT_INIT, S_HUNT_RD, S_HUNT_CMP, S_LEN_CHK, S_LEN_GET,
    S_LEN_EVAL, S_SUM_RD, S_SUM_ACC, S_EMPTY, S_EMIT_RD, S_EMIT_WR
  } state_e;

  typedef enum logic [1:0] {RD_K, RD_LEN, RD_PAY} rd_sel_e;

  typedef enum logic [2:0] {DROP_KM1, DROP_ALL, DROP_2, DROP_3, DROP_PKT} drop_sel_e;

  typedef struct packed {
    logic      ld_item;
    logic      append;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      k_clr;
    logic      k_inc;
    logic      prev_ld;
    logic      drop_en;
    drop_sel_e drop_sel;
    logic      len_ld;
    logic      sum_clr;
    logic      sum_acc;
    logic      i_clr;
    logic      i_inc;
    logic      emit;
    logic [2:0] emit_st;
    logic      nres_clr;
  } cmd_t;

  typedef struct packed {
    logic src_bad;
    logic full;
    logic cnt_zero;
    logic k_end;
    logic k_pos;
    logic pair_hit;
    logic prev_hf;
    logic cnt_lt3;
    logic len_bad;
    logic len_short;
    logic len_zero;
    logic i_end;
    logic i_last;
    logic sum_ok;
    logic budget_one;
    logic budget_pkt;
    logic out_free;
  } sts_t;

endpackage

### src/psd_ram.sv
// ----------------------------------------------------------------------------
// psd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/psd_ctrl.sv
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer: append, header hunt, length check, checksum walk, payload emit.
// ----------------------------------------------------------------------------
module psd_ctrl
  import psd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel   = RD_K;
    cmd_o.drop_sel = DROP_ALL;
    cmd_o.emit_st  = StData;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_item  = 1'b1;
          cmd_o.nres_clr = 1'b1;
          state_d        = S_APPEND;
        end
      end
      S_APPEND: begin
        if (sts_i.src_bad) begin
          state_d = S_IDLE;
        end else if (!sts_i.full) begin
          cmd_o.append = 1'b1;
          state_d      = S_HUNT_INIT;
        end else if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.emit_st = StOverflow;
          state_d       = S_HUNT_INIT;
        end
      end
      S_HUNT_INIT: begin
        cmd_o.k_clr = 1'b1;
        state_d     = S_HUNT_RD;
      end
      S_HUNT_RD: begin
        if (sts_i.k_end) begin
          cmd_o.drop_en  = 1'b1;
          cmd_o.drop_sel = (!sts_i.cnt_zero && sts_i.prev_hf) ? DROP_KM1 : DROP_ALL;
          state_d        = S_LEN_CHK;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_K;
          state_d      = S_HUNT_CMP;
        end
      end
      S_HUNT_CMP: begin
        if (sts_i.k_pos && sts_i.pair_hit) begin
          cmd_o.drop_en  = 1'b1;
          cmd_o.drop_sel = DROP_KM1;
          state_d        = S_LEN_CHK;
        end else begin
          cmd_o.prev_ld = 1'b1;
          cmd_o.k_inc   = 1'b1;
          state_d       = S_HUNT_RD;
        end
      end
      S_LEN_CHK: begin
        if (sts_i.cnt_lt3) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LEN;
          state_d      = S_LEN_GET;
        end
      end
      S_LEN_GET: begin
        cmd_o.len_ld = 1'b1;
        state_d      = S_LEN_EVAL;
      end
      S_LEN_EVAL: begin
        if (sts_i.len_bad) begin
          if (sts_i.budget_one) begin
            state_d = S_IDLE;
          end else if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_st  = StLength;
            cmd_o.drop_en  = 1'b1;
            cmd_o.drop_sel = DROP_2;
            state_d        = S_HUNT_INIT;
          end
        end else if (sts_i.len_short) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.sum_clr = 1'b1;
          cmd_o.i_clr   = 1'b1;
          state_d       = S_SUM_RD;
        end
      end
      S_SUM_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PAY;
        state_d      = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        if (!sts_i.i_end) begin
          cmd_o.sum_acc = 1'b1;
          cmd_o.i_inc   = 1'b1;
          state_d       = S_SUM_RD;
        end else if (sts_i.sum_ok) begin
          if (sts_i.budget_pkt) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.i_clr = 1'b1;
            state_d     = sts_i.len_zero ? S_EMPTY : S_EMIT_RD;
          end
        end else if (sts_i.budget_one) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_st  = StChecksum;
          cmd_o.drop_en  = 1'b1;
          cmd_o.drop_sel = DROP_3;
          state_d        = S_HUNT_INIT;
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_st  = StEmpty;
          cmd_o.drop_en  = 1'b1;
          cmd_o.drop_sel = DROP_PKT;
          state_d        = S_HUNT_INIT;
        end
      end
      S_EMIT_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PAY;
        state_d      = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.emit_st = StData;
          if (sts_i.i_last) begin
            cmd_o.drop_en  = 1'b1;
            cmd_o.drop_sel = DROP_PKT;
            state_d        = S_HUNT_INIT;
          end else begin
            cmd_o.i_inc = 1'b1;
            state_d     = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### src/psd_dp.sv
// ----------------------------------------------------------------------------
// psd_dp
// Datapath: ring pointers per source, byte store, scan/sum registers, output.
// ----------------------------------------------------------------------------
module psd_dp
  import psd_pkg::*;
#(
  parameter int NUM_SOURCES  = NumSourcesDef,
  parameter int BUFFER_DEPTH = BufferDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] source_id_i,
  input  logic [7:0] data_byte_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [3:0] out_source_o,
  output logic [7:0] payload_byte_o,
  output logic       last_of_packet_o,
  output logic [2:0] status_o,
  input  cmd_t       cmd_i,
  output sts_t       sts_o
);

  localparam int SrcW   = $clog2(NUM_SOURCES);
  localparam int IdxW   = $clog2(BUFFER_DEPTH);
  localparam int CntW   = $clog2(BUFFER_DEPTH + 1);
  localparam int SumW   = CntW + 1;
  localparam int LimCap = (MaxResults + 1 < BUFFER_DEPTH - 3) ? MaxResults + 1
                                                               : BUFFER_DEPTH - 3;

  logic [7:0] hdr1_q, hdr2_q;
  logic [6:0] limit_q;
  logic [3:0] src_q;
  logic [7:0] byte_q;
  logic [IdxW-1:0] head_q [NUM_SOURCES];
  logic [CntW-1:0] cnt_q  [NUM_SOURCES];
  logic [CntW-1:0] k_q;
  logic [7:0] prev_q, len_q, sum_q, i_q;
  logic [NresW-1:0] nres_q;
  logic       out_valid_q, out_last_q;
  logic [3:0] out_src_q;
  logic [7:0] out_byte_q;
  logic [2:0] out_st_q;

  logic [SrcW-1:0] sidx;
  logic [IdxW-1:0] cur_head, ridx, widx, new_head;
  logic [CntW-1:0] cur_cnt, roff, amt;
  logic [7:0] rdata, lim8, need8;
  logic       out_free;

  function automatic logic [IdxW-1:0] ring_add(logic [IdxW-1:0] base, logic [CntW-1:0] off);
    logic [SumW-1:0] s;
    s = SumW'(base) + SumW'(off);
    if (s >= SumW'(BUFFER_DEPTH)) begin
      s = s - SumW'(BUFFER_DEPTH);
    end
    return s[IdxW-1:0];
  endfunction

  assign sidx     = src_q[SrcW-1:0];
  assign cur_head = head_q[sidx];
  assign cur_cnt  = cnt_q[sidx];

  always_comb begin
    case (cmd_i.rd_sel)
      RD_K:    roff = k_q;
      RD_LEN:  roff = CntW'(2);
      RD_PAY:  roff = CntW'(i_q + 8'd3);
      default: roff = k_q;
    endcase
    case (cmd_i.drop_sel)
      DROP_KM1: amt = k_q - CntW'(1);
      DROP_2:   amt = CntW'(2);
      DROP_3:   amt = CntW'(3);
      DROP_PKT: amt = CntW'(len_q + 8'd4);
      default:  amt = cur_cnt;
    endcase
  end

  assign ridx     = ring_add(cur_head, roff);
  assign widx     = ring_add(cur_head, cur_cnt);
  assign new_head = ring_add(cur_head, amt);

  psd_ram #(
    .WIDTH(8),
    .DEPTH(NUM_SOURCES << IdxW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.append),
    .waddr_i({sidx, widx}),
    .wdata_i(byte_q),
    .re_i   (cmd_i.rd_en),
    .raddr_i({sidx, ridx}),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr1_q  <= HeaderFirstRst;
      hdr2_q  <= HeaderSecondRst;
      limit_q <= LengthLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHeaderFirst:  hdr1_q  <= cfg_data_i;
        CfgHeaderSecond: hdr2_q  <= cfg_data_i;
        CfgLengthLimit:  limit_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        head_q[s] <= '0;
        cnt_q[s]  <= '0;
      end
    end else if (cmd_i.append) begin
      cnt_q[sidx] <= cur_cnt + CntW'(1);
    end else if (cmd_i.drop_en) begin
      if (cmd_i.drop_sel == DROP_ALL) begin
        cnt_q[sidx] <= '0;
      end else begin
        cnt_q[sidx]  <= cur_cnt - amt;
        head_q[sidx] <= new_head;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      src_q  <= source_id_i;
      byte_q <= data_byte_i;
    end
    if (cmd_i.k_clr) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + CntW'(1);
    end
    if (cmd_i.prev_ld) begin
      prev_q <= rdata;
    end
    if (cmd_i.len_ld) begin
      len_q <= rdata;
    end
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end else if (cmd_i.sum_acc) begin
      sum_q <= sum_q + rdata;
    end
    if (cmd_i.i_clr) begin
      i_q <= '0;
    end else if (cmd_i.i_inc) begin
      i_q <= i_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nres_q <= '0;
    end else if (cmd_i.nres_clr) begin
      nres_q <= '0;
    end else if (cmd_i.emit) begin
      nres_q <= nres_q + NresW'(1);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_src_q  <= src_q;
      out_st_q   <= cmd_i.emit_st;
      out_byte_q <= (cmd_i.emit_st == StData) ? rdata : 8'd0;
      out_last_q <= (cmd_i.emit_st == StData) ? (i_q + 8'd1 == len_q) : 1'b1;
    end
  end

  assign lim8  = (8'(limit_q) < 8'(LimCap)) ? 8'(limit_q) : 8'(LimCap);
  assign need8 = (len_q == 8'd0) ? 8'd1 : len_q;

  always_comb begin
    sts_o            = '0;
    sts_o.src_bad    = (5'(src_q) >= 5'(NUM_SOURCES));
    sts_o.full       = (cur_cnt == CntW'(BUFFER_DEPTH));
    sts_o.cnt_zero   = (cur_cnt == '0);
    sts_o.k_end      = (k_q == cur_cnt);
    sts_o.k_pos      = (k_q != '0);
    sts_o.pair_hit   = (prev_q == hdr1_q) && (rdata == hdr2_q);
    sts_o.prev_hf    = (prev_q == hdr1_q);
    sts_o.cnt_lt3    = (cur_cnt < CntW'(3));
    sts_o.len_bad    = (len_q >= lim8);
    sts_o.len_short  = ({1'b0, len_q} + 9'd4 > 9'(cur_cnt));
    sts_o.len_zero   = (len_q == 8'd0);
    sts_o.i_end      = (i_q == len_q);
    sts_o.i_last     = (i_q + 8'd1 == len_q);
    sts_o.sum_ok     = (sum_q == rdata);
    sts_o.budget_one = (nres_q == NresW'(MaxResults));
    sts_o.budget_pkt = (8'(nres_q) + need8 > 8'(MaxResults));
    sts_o.out_free   = out_free;
  end

  assign out_valid_o      = out_valid_q;
  assign out_source_o     = out_src_q;
  assign payload_byte_o   = out_byte_q;
  assign last_of_packet_o = out_last_q;
  assign status_o         = out_st_q;

endmodule

### src/per_source_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// per_source_packet_deframer_top
// Per-source reassembly of length-prefixed packets with additive checksum.
// ----------------------------------------------------------------------------
// Input channel: one beat carries source_id_i and data_byte_i, taken when
// in_valid_i is high and in_stall_o is low. in_stall_o stays high while the
// byte is appended and its buffer is rescanned.
// Output channel: one beat per result (payload byte or event), held in an
// output register until taken (out_valid_o high, out_stall_i low).
// Steps from one accepted beat to the next: accept, append, hunt setup,
// header hunt over the stored bytes, length check, length read and evaluate.
// A packet that passes these steps adds a checksum walk over its payload
// bytes and checksum byte, then a read and a send for each result; every
// step is bound by the single read port of the byte store.
// The earliest result is an overflow event from the append step.
// A stalled receiver holds the sequencer at its next result; no beat is lost.
// Reset clears all fill counts and restores the header and limit registers;
// no store clearing pass is needed. Configure only while idle.
// ----------------------------------------------------------------------------
`include "per_source_packet_deframer_top_assert.svh"

module per_source_packet_deframer_top
  import psd_pkg::*;
#(
  parameter int NUM_SOURCES  = NumSourcesDef,
  parameter int BUFFER_DEPTH = BufferDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] source_id_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] out_source_o,
  output logic [7:0] payload_byte_o,
  output logic       last_of_packet_o,
  output logic [2:0] status_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  psd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  psd_dp #(
    .NUM_SOURCES (NUM_SOURCES),
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .source_id_i     (source_id_i),
    .data_byte_i     (data_byte_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_source_o    (out_source_o),
    .payload_byte_o  (payload_byte_o),
    .last_of_packet_o(last_of_packet_o),
    .status_o        (status_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

  `PSD_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `PSD_ASSERT_IMP(a_event_is_last, out_valid_o && (status_o != StData), last_of_packet_o)
  `PSD_ASSERT_IMP(a_event_no_byte, out_valid_o && (status_o != StData), payload_byte_o == 8'd0)

endmodule
